[sv/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, widths and constants of the multichannel moving average.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int CHANNELS   = 4;
  localparam int MAX_LENGTH = 64;

  localparam int CH_W      = $clog2(CHANNELS);
  localparam int POS_W     = $clog2(MAX_LENGTH);
  localparam int ADDR_W    = CH_W + POS_W;
  localparam int DEPTH     = CHANNELS * MAX_LENGTH;
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 7;
  localparam int SUM_W     = 23;
  localparam int DIV_W     = SUM_W - 1;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam int PDATA_W   = 32;

  // register map (index = byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_CH0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PREFILL    = 3'd4;

  localparam logic [LEN_W-1:0]    LEN_RESET     = 7'd40;
  localparam logic [LEN_W-1:0]    LEN_RESET_CH3 = 7'd15;
  localparam logic [CHANNELS-1:0] PREFILL_RESET = 4'hF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

  // zero counts as one, anything past the window capacity as the capacity
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_LENGTH)) begin
      len = LEN_W'(MAX_LENGTH);
    end
    return len;
  endfunction

endpackage

[sv/mma_if.sv]
// ----------------------------------------------------------------------------
// mma_sample_if / mma_average_if
// Valid/ready channels for incoming samples and outgoing averages.
// ----------------------------------------------------------------------------
interface mma_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mma_pkg::SAMPLE_W-1:0]  sample;
  logic        [mma_pkg::CH_W-1:0]      channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface mma_average_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mma_pkg::SAMPLE_W-1:0]  average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

[sv/multichannel_moving_average.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Four boxcar moving averages sharing one window memory and one divider.
// ----------------------------------------------------------------------------
// Per sample: read, update, 22 restoring-divide steps, output load. One sample
//   in flight at a time, so a new sample is taken only after the last one's
//   average is loaded. A waiting average stalls the output load.
// The output register lets the next sample start while an average waits.
// Reset (rst, synchronous): lengths 40/40/40/15, prefill on for all channels,
//   sums, positions and windows zero. No clearing pass: per-entry valid bits.
// ----------------------------------------------------------------------------
module multichannel_moving_average (
  input  logic                          clk,
  input  logic                          rst,
  mma_sample_if.sink                    samples,
  mma_average_if.source                 averages,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mma_pkg::PADDR_W-1:0]   paddr,
  input  logic [mma_pkg::PDATA_W-1:0]   pwdata,
  output logic [mma_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // configuration
  logic [mma_pkg::LEN_W-1:0]    length [mma_pkg::CHANNELS];
  logic [mma_pkg::CHANNELS-1:0] prefill_mask;

  // per-channel state
  logic signed [mma_pkg::SUM_W-1:0]    sums     [mma_pkg::CHANNELS];
  logic        [mma_pkg::POS_W-1:0]    pos      [mma_pkg::CHANNELS];
  logic signed [mma_pkg::SAMPLE_W-1:0] fill     [mma_pkg::CHANNELS];
  logic        [mma_pkg::CHANNELS-1:0] first_pending;
  logic        [mma_pkg::DEPTH-1:0]    entry_valid;

  // window memory
  logic signed [mma_pkg::SAMPLE_W-1:0] mem [mma_pkg::DEPTH];
  logic signed [mma_pkg::SAMPLE_W-1:0] rdata;

  // sequencer
  mma_pkg::state_t state, state_next;
  logic mem_re, mem_we, div_step, out_load, in_acc;

  // item registers
  logic        [mma_pkg::CH_W-1:0]     ch_q;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample_q;
  logic        [mma_pkg::LEN_W-1:0]    len_q;
  logic                                pend_q;
  logic        [mma_pkg::ADDR_W-1:0]   addr_q;
  logic signed [mma_pkg::SAMPLE_W-1:0] old_q;
  logic signed [mma_pkg::SUM_W-1:0]    base_q;
  logic                                neg_q;
  logic        [mma_pkg::DIV_W-1:0]    dividend;
  logic        [mma_pkg::LEN_W-1:0]    rem;
  logic        [mma_pkg::CNT_W-1:0]    cnt;

  // accept-time lookups
  logic [mma_pkg::LEN_W-1:0]  in_len;
  logic [mma_pkg::POS_W-1:0]  in_pos;
  logic [mma_pkg::ADDR_W-1:0] in_addr;

  // update arithmetic
  logic signed [mma_pkg::LEN_W+mma_pkg::SAMPLE_W:0] prod_full;
  logic signed [mma_pkg::SUM_W-1:0]    new_sum;
  logic        [mma_pkg::SUM_W-1:0]    new_mag;
  logic        [mma_pkg::LEN_W:0]      pos_inc;
  logic        [mma_pkg::POS_W-1:0]    pos_adv;
  logic        [mma_pkg::LEN_W:0]      rem_shift;
  logic        [mma_pkg::LEN_W:0]      rem_diff;
  logic                                q_bit;
  logic        [mma_pkg::DIV_W-1:0]    q_signed;

  // config decode
  logic                              cfg_we;
  logic [mma_pkg::REG_IDX_W-1:0]     cfg_idx;
  logic [mma_pkg::CH_W-1:0]          cfg_ch;
  logic                              cfg_is_len;

  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite;
  assign cfg_idx    = paddr[mma_pkg::PADDR_W-1:2];
  assign cfg_ch     = cfg_idx[mma_pkg::CH_W-1:0];
  assign cfg_is_len = (cfg_idx < mma_pkg::REG_IDX_W'(mma_pkg::CHANNELS));

  always_comb begin
    prdata = '0;
    if (cfg_is_len) begin
      prdata = mma_pkg::PDATA_W'(length[cfg_ch]);
    end else if (cfg_idx == mma_pkg::REG_PREFILL) begin
      prdata = mma_pkg::PDATA_W'(prefill_mask);
    end
  end

  assign in_acc = samples.valid & samples.ready;

  // wrap a stale position back to the start of the window
  always_comb begin
    in_len = mma_pkg::eff_len(length[samples.channel]);
    in_pos = pos[samples.channel];
    if ({1'b0, in_pos} >= in_len) begin
      in_pos = '0;
    end
    in_addr = {samples.channel, in_pos};
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mma_pkg::ST_IDLE:   if (in_acc) state_next = mma_pkg::ST_READ;
      mma_pkg::ST_READ:   state_next = mma_pkg::ST_UPDATE;
      mma_pkg::ST_UPDATE: state_next = mma_pkg::ST_DIV;
      mma_pkg::ST_DIV:    if (cnt == '0) state_next = mma_pkg::ST_DONE;
      mma_pkg::ST_DONE:   if (!averages.valid || averages.ready) begin
        state_next = mma_pkg::ST_IDLE;
      end
      default:            state_next = mma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (state == mma_pkg::ST_IDLE);
    mem_re        = in_acc;
    mem_we        = (state == mma_pkg::ST_UPDATE);
    div_step      = (state == mma_pkg::ST_DIV);
    out_load      = (state == mma_pkg::ST_DONE) && (!averages.valid || averages.ready);
  end

  // ---------------- window memory ----------------
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[in_addr];
    end
    if (mem_we) begin
      mem[addr_q] <= sample_q;
    end
  end

  // ---------------- datapath ----------------
  assign prod_full = $signed({1'b0, len_q}) * sample_q;

  always_comb begin
    new_sum = base_q
            + {{(mma_pkg::SUM_W-mma_pkg::SAMPLE_W){sample_q[mma_pkg::SAMPLE_W-1]}}, sample_q}
            - {{(mma_pkg::SUM_W-mma_pkg::SAMPLE_W){old_q[mma_pkg::SAMPLE_W-1]}}, old_q};
    new_mag = new_sum[mma_pkg::SUM_W-1] ? (~new_sum + 1'b1) : new_sum;
    pos_inc = {2'b00, addr_q[mma_pkg::POS_W-1:0]} + 1'b1;
    pos_adv = (pos_inc >= {1'b0, len_q}) ? '0 : pos_inc[mma_pkg::POS_W-1:0];
  end

  // one quotient bit per step
  always_comb begin
    rem_shift = {rem, dividend[mma_pkg::DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, len_q};
    q_bit     = (rem_shift >= {1'b0, len_q});
    q_signed  = neg_q ? (~dividend + 1'b1) : dividend;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_q     <= samples.channel;
      sample_q <= samples.sample;
      len_q    <= in_len;
      pend_q   <= first_pending[samples.channel];
      addr_q   <= in_addr;
    end
    if (state == mma_pkg::ST_READ) begin
      // untouched entries read as the channel's fill value, or as the sample itself while prefill is pending
      if (entry_valid[addr_q]) begin
        old_q <= rdata;
      end else if (pend_q) begin
        old_q <= sample_q;
      end else begin
        old_q <= fill[ch_q];
      end
      base_q <= pend_q ? prod_full[mma_pkg::SUM_W-1:0] : sums[ch_q];
    end
    if (state == mma_pkg::ST_UPDATE) begin
      neg_q    <= new_sum[mma_pkg::SUM_W-1];
      dividend <= new_mag[mma_pkg::DIV_W-1:0];
      rem      <= '0;
      cnt      <= mma_pkg::CNT_W'(mma_pkg::DIV_W - 1);
    end
    if (div_step) begin
      rem      <= q_bit ? rem_diff[mma_pkg::LEN_W-1:0] : rem_shift[mma_pkg::LEN_W-1:0];
      dividend <= {dividend[mma_pkg::DIV_W-2:0], q_bit};
      cnt      <= cnt - 1'b1;
    end
  end

  // ---------------- channel state and registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
        length[c] <= (c == 3) ? mma_pkg::LEN_RESET_CH3 : mma_pkg::LEN_RESET;
        sums[c]   <= '0;
        pos[c]    <= '0;
        fill[c]   <= '0;
      end
      prefill_mask  <= mma_pkg::PREFILL_RESET;
      first_pending <= mma_pkg::PREFILL_RESET;
      entry_valid   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_is_len) begin
          // restart the channel
          length[cfg_ch]        <= pwdata[mma_pkg::LEN_W-1:0];
          sums[cfg_ch]          <= '0;
          pos[cfg_ch]           <= '0;
          fill[cfg_ch]          <= '0;
          first_pending[cfg_ch] <= prefill_mask[cfg_ch];
          for (int e = 0; e < mma_pkg::DEPTH; e++) begin
            if ((e / mma_pkg::MAX_LENGTH) == int'(cfg_ch)) begin
              entry_valid[e] <= 1'b0;
            end
          end
        end else if (cfg_idx == mma_pkg::REG_PREFILL) begin
          prefill_mask <= pwdata[mma_pkg::CHANNELS-1:0];
        end
      end
      if (state == mma_pkg::ST_UPDATE) begin
        sums[ch_q]          <= new_sum;
        pos[ch_q]           <= pos_adv;
        entry_valid[addr_q] <= 1'b1;
        if (pend_q) begin
          fill[ch_q]          <= sample_q;
          first_pending[ch_q] <= 1'b0;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      averages.valid <= 1'b0;
    end else if (out_load) begin
      averages.valid <= 1'b1;
    end else if (averages.ready) begin
      averages.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      averages.average <= q_signed[mma_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

[verif/multichannel_moving_average_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_average_tb
// Drives samples on four channels and predicts each boxcar average from a
// shadow copy of the windows, sums, write positions and registers. Window
// lengths and prefill are rewritten over the APB port between phases, while
// both channel sides idle and stall at random outside the steady phase.
// ----------------------------------------------------------------------------
module multichannel_moving_average_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 115;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [mma_pkg::REG_IDX_W-1:0]      REG_UNUSED = 3'd5;
  localparam logic signed [mma_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [mma_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mma_pkg::PADDR_W-1:0]  paddr;
  logic [mma_pkg::PDATA_W-1:0]  pwdata;
  logic [mma_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  mma_sample_if  samples_bus ();
  mma_average_if averages_bus ();

  multichannel_moving_average DUT (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_bus),
    .averages (averages_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow state of the filters
  logic signed [mma_pkg::SAMPLE_W-1:0] window_mem [mma_pkg::CHANNELS][mma_pkg::MAX_LENGTH];
  int                                  chan_sum   [mma_pkg::CHANNELS];
  int                                  chan_pos   [mma_pkg::CHANNELS];
  logic [mma_pkg::LEN_W-1:0]           len_reg    [mma_pkg::CHANNELS];
  logic [mma_pkg::CHANNELS-1:0]        prefill_reg;
  logic [mma_pkg::CHANNELS-1:0]        fill_pending;

  logic signed [mma_pkg::SAMPLE_W-1:0] expected_averages [$];
  logic signed [mma_pkg::SAMPLE_W-1:0] wanted_average;
  int                                  mismatch_count;
  int                                  cycle_count;
  bit                                  steady_mode;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multichannel_moving_average: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    averages_bus.ready <= steady_mode || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst && averages_bus.valid && averages_bus.ready) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: average %0d with none expected", $time, averages_bus.average);
        mismatch_count++;
      end else begin
        wanted_average = expected_averages.pop_front();
        if (averages_bus.average !== wanted_average) begin
          $display("%0t: average expected %0d actual %0d", $time, wanted_average,
                   averages_bus.average);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int window_length(input logic [mma_pkg::LEN_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > mma_pkg::MAX_LENGTH) return mma_pkg::MAX_LENGTH;
    return int'(raw);
  endfunction

  function automatic void restart_channel(input int ch);
    for (int i = 0; i < mma_pkg::MAX_LENGTH; i++) window_mem[ch][i] = '0;
    chan_sum[ch]     = 0;
    chan_pos[ch]     = 0;
    fill_pending[ch] = prefill_reg[ch];
  endfunction

  function automatic logic signed [mma_pkg::SAMPLE_W-1:0] predict_average(
      input logic signed [mma_pkg::SAMPLE_W-1:0] s, input logic [mma_pkg::CH_W-1:0] ch);
    int len;
    int pos;
    int avg;
    len = window_length(len_reg[ch]);
    if (fill_pending[ch]) begin
      for (int i = 0; i < len; i++) window_mem[ch][i] = s;
      chan_sum[ch]     = len * s;
      fill_pending[ch] = 1'b0;
    end
    pos = chan_pos[ch];
    if (pos >= len) pos = 0;
    chan_sum[ch] += s - window_mem[ch][pos];
    window_mem[ch][pos] = s;
    pos++;
    if (pos >= len) pos = 0;
    chan_pos[ch] = pos;
    avg = chan_sum[ch] / len;
    return avg[mma_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [mma_pkg::SAMPLE_W-1:0] pick_sample(
      input bit extremes_only);
    if (extremes_only) return ($urandom_range(7) == 0) ? SAMPLE_MAX : SAMPLE_MIN;
    unique case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return mma_pkg::SAMPLE_W'(int'($urandom_range(8)) - 4);
      default: return mma_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [mma_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return mma_pkg::LEN_W'(mma_pkg::MAX_LENGTH);
    if (r < 15) return mma_pkg::LEN_W'($urandom_range(127, mma_pkg::MAX_LENGTH + 1));
    if (r < 25) return mma_pkg::LEN_W'(1);
    return mma_pkg::LEN_W'($urandom_range(16, 2));
  endfunction

  // all driving tasks start and end on a falling edge
  task automatic push_sample(input logic signed [mma_pkg::SAMPLE_W-1:0] s,
                             input logic [mma_pkg::CH_W-1:0] ch);
    while (!steady_mode && $urandom_range(99) < 23) begin
      samples_bus.valid <= 1'b0;
      @(negedge clk);
    end
    samples_bus.valid   <= 1'b1;
    samples_bus.sample  <= s;
    samples_bus.channel <= ch;
    do @(posedge clk); while (!samples_bus.ready);
    expected_averages.push_back(predict_average(s, ch));
    @(negedge clk);
  endtask

  // hold off until every average is back, so the block is idle
  task automatic wait_for_averages();
    samples_bus.valid <= 1'b0;
    @(negedge clk);
    while (expected_averages.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [mma_pkg::REG_IDX_W-1:0] idx,
                                input logic [mma_pkg::LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= mma_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < mma_pkg::REG_PREFILL) begin
      len_reg[idx - mma_pkg::REG_LENGTH_CH0] = value;
      restart_channel(int'(idx - mma_pkg::REG_LENGTH_CH0));
    end else if (idx == mma_pkg::REG_PREFILL) begin
      prefill_reg = value[mma_pkg::CHANNELS-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    push_sample(SAMPLE_MAX, 2'd0);
    push_sample(SAMPLE_MIN, 2'd0);
    push_sample(SAMPLE_MIN, 2'd1);
    push_sample(16'sd0, 2'd2);
    push_sample(16'sd5, 2'd2);
    push_sample(-16'sd1, 2'd3);
    push_sample(16'sd1, 2'd3);
    wait_for_averages();
  endtask

  task automatic test_length_limits();
    // prefill only on channels 0 and 2; takes effect at the restarts below
    write_register(mma_pkg::REG_PREFILL, mma_pkg::LEN_W'(4'b0101));
    write_register(mma_pkg::REG_LENGTH_CH0 + 3'd0, mma_pkg::LEN_W'(1));
    write_register(mma_pkg::REG_LENGTH_CH0 + 3'd1, mma_pkg::LEN_W'(mma_pkg::MAX_LENGTH));
    write_register(mma_pkg::REG_LENGTH_CH0 + 3'd2, '0);
    write_register(mma_pkg::REG_LENGTH_CH0 + 3'd3, mma_pkg::LEN_W'(127));
    write_register(REG_UNUSED, mma_pkg::LEN_W'(9));
    push_sample(SAMPLE_MIN, 2'd0);
    push_sample(SAMPLE_MAX, 2'd0);
    push_sample(SAMPLE_MAX, 2'd1);
    push_sample(SAMPLE_MAX, 2'd1);
    push_sample(-16'sd7, 2'd1);
    push_sample(SAMPLE_MIN, 2'd2);
    push_sample(SAMPLE_MIN, 2'd3);
    push_sample(SAMPLE_MIN, 2'd3);
    push_sample(-16'sd100, 2'd3);
    wait_for_averages();
    // mask change alone must not restart channel 1
    write_register(mma_pkg::REG_PREFILL, mma_pkg::LEN_W'(4'b1010));
    push_sample(16'sd3, 2'd1);
    wait_for_averages();
    write_register(mma_pkg::REG_LENGTH_CH0 + 3'd1, mma_pkg::LEN_W'(mma_pkg::MAX_LENGTH));
    push_sample(SAMPLE_MIN, 2'd1);
    push_sample(SAMPLE_MAX, 2'd1);
    wait_for_averages();
  endtask

  task automatic test_random_traffic();
    bit extremes_only;
    for (int phase = 0; phase < PHASES; phase++) begin
      extremes_only = (phase == 1);
      if ($urandom_range(1) == 0 || phase < 3)
        write_register(mma_pkg::REG_PREFILL, mma_pkg::LEN_W'($urandom_range(15)));
      for (int ch = 0; ch < mma_pkg::CHANNELS; ch++) begin
        if (phase == 1) begin
          write_register(mma_pkg::REG_LENGTH_CH0 + mma_pkg::REG_IDX_W'(ch),
                         mma_pkg::LEN_W'(mma_pkg::MAX_LENGTH));
        end else if (phase == 2) begin
          write_register(mma_pkg::REG_LENGTH_CH0 + mma_pkg::REG_IDX_W'(ch),
                         mma_pkg::LEN_W'(1));
        end else if ($urandom_range(99) < 70) begin
          write_register(mma_pkg::REG_LENGTH_CH0 + mma_pkg::REG_IDX_W'(ch), pick_length());
        end
      end
      steady_mode = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_for_averages();
        push_sample(pick_sample(extremes_only),
                    mma_pkg::CH_W'($urandom_range(mma_pkg::CHANNELS - 1)));
      end
      wait_for_averages();
      steady_mode = 1'b0;
    end
  endtask

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    samples_bus.valid    = 1'b0;
    samples_bus.sample   = '0;
    samples_bus.channel  = '0;
    averages_bus.ready   = 1'b0;
    mismatch_count       = 0;
    cycle_count          = 0;
    steady_mode          = 1'b0;
    len_reg[0]           = mma_pkg::LEN_RESET;
    len_reg[1]           = mma_pkg::LEN_RESET;
    len_reg[2]           = mma_pkg::LEN_RESET;
    len_reg[3]           = mma_pkg::LEN_RESET_CH3;
    prefill_reg          = mma_pkg::PREFILL_RESET;
    for (int ch = 0; ch < mma_pkg::CHANNELS; ch++) restart_channel(ch);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_length_limits();
    test_random_traffic();

    wait_for_averages();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("multichannel_moving_average: match");
    end else begin
      $display("multichannel_moving_average: mismatch");
    end
    $finish;
  end

endmodule

[multichannel_moving_average.f]
sv/mma_pkg.sv
sv/mma_if.sv
sv/multichannel_moving_average.sv
verif/multichannel_moving_average_tb.sv
